// ----- src/bdts_pkg.sv -----
`timescale 1ns / 1ps

package bdts_pkg;

  // Field widths
  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 12;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int CursorW = 2;
  localparam int KeyW    = 3;

  // Stream widths (fields packed from bit 0, padded to whole bytes)
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;

  // Opcodes
  localparam logic OP_BUTTON = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // Edit modes
  localparam logic MODE_DATE = 1'b0;
  localparam logic MODE_TIME = 1'b1;

  // Key codes; codes above KEY_NONE do nothing
  localparam logic [KeyW-1:0] KEY_SELECT = 3'd0;
  localparam logic [KeyW-1:0] KEY_RIGHT  = 3'd1;
  localparam logic [KeyW-1:0] KEY_LEFT   = 3'd2;
  localparam logic [KeyW-1:0] KEY_UP     = 3'd3;
  localparam logic [KeyW-1:0] KEY_DOWN   = 3'd4;
  localparam logic [KeyW-1:0] KEY_NONE   = 3'd5;

  // Configuration register indexes
  localparam logic CFG_YEAR_MIN = 1'b0;
  localparam logic CFG_YEAR_MAX = 1'b1;

  // Cursor positions
  localparam logic [CursorW-1:0] CUR_FIRST  = 2'd0;
  localparam logic [CursorW-1:0] CUR_SECOND = 2'd1;
  localparam logic [CursorW-1:0] CUR_THIRD  = 2'd2;
  localparam logic [CursorW-1:0] CUR_TOP_DATE = 2'd2;
  localparam logic [CursorW-1:0] CUR_TOP_TIME = 2'd1;

  // Reset values
  localparam logic [YearW-1:0]   YEAR_MIN_RST = 12'd2017;
  localparam logic [YearW-1:0]   YEAR_MAX_RST = 12'd2117;
  localparam logic [DayW-1:0]    DAY_RST      = 5'd1;
  localparam logic [MonthW-1:0]  MONTH_RST    = 4'd1;
  localparam logic [YearW-1:0]   YEAR_RST     = 12'd2017;
  localparam logic [HourW-1:0]   HOUR_RST     = 5'd12;
  localparam logic [MinuteW-1:0] MINUTE_RST   = 6'd0;
  localparam logic [CursorW-1:0] CURSOR_RST   = 2'd0;

  // Wrap limits
  localparam logic [HourW-1:0]   HOUR_LAST   = 5'd23;
  localparam logic [MinuteW-1:0] MINUTE_LAST = 6'd59;
  localparam logic [MonthW-1:0]  MONTH_LAST  = 4'd12;

  // Divisibility by 25 of a 12-bit year: multiply by the inverse of 25
  // mod 4096; multiples of 25 map onto 0..163 and nothing else does.
  localparam logic [YearW-1:0] INV25     = 12'd3113;
  localparam logic [YearW-1:0] MAX_Q25   = 12'd163;

  typedef struct packed {
    logic [DayW-1:0]    day;
    logic [MonthW-1:0]  month;
    logic [YearW-1:0]   year;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [CursorW-1:0] cursor;
  } state_t;

  typedef struct packed {
    logic               opcode;
    logic [KeyW-1:0]    key;
    logic               edit_mode;
    logic [YearW-1:0]   load_year;
    logic [MonthW-1:0]  load_month;
    logic [DayW-1:0]    load_day;
    logic [HourW-1:0]   load_hour;
    logic [MinuteW-1:0] load_minute;
  } item_t;

  // Gregorian leap year
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] prod;
    logic             div25;
    prod  = y * INV25;
    div25 = (prod <= MAX_Q25);
    return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
  endfunction

  // Days in a month; zero for an invalid month
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic [YearW-1:0] y);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
      4'd2:    len = is_leap(y) ? 5'd29 : 5'd28;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// ----- src/bdts_calc.sv -----
`timescale 1ns / 1ps

module bdts_calc (
  input  bdts_pkg::state_t                cur,
  input  bdts_pkg::item_t                 item,
  input  logic [bdts_pkg::YearW-1:0]      year_min,
  input  logic [bdts_pkg::YearW-1:0]      year_max,
  output bdts_pkg::state_t                nxt,
  output logic                            commit
);

  logic [bdts_pkg::CursorW-1:0] top;
  logic [bdts_pkg::CursorW:0]   cur_inc;
  logic [bdts_pkg::CursorW-1:0] cur_dec;
  logic [bdts_pkg::DayW-1:0]    len;
  logic [bdts_pkg::DayW:0]      day_inc;
  logic [bdts_pkg::MonthW:0]    month_inc;
  logic [bdts_pkg::HourW:0]     hour_inc;
  logic [bdts_pkg::MinuteW:0]   minute_inc;
  logic                         up;

  assign top = (item.edit_mode == bdts_pkg::MODE_DATE) ? bdts_pkg::CUR_TOP_DATE
                                                       : bdts_pkg::CUR_TOP_TIME;
  assign cur_inc    = {1'b0, cur.cursor} + 3'd1;
  assign len        = bdts_pkg::month_len(cur.month, cur.year);
  assign day_inc    = {1'b0, cur.day} + 6'd1;
  assign month_inc  = {1'b0, cur.month} + 5'd1;
  assign hour_inc   = {1'b0, cur.hour} + 6'd1;
  assign minute_inc = {1'b0, cur.minute} + 7'd1;
  assign up         = (item.key == bdts_pkg::KEY_UP);

  // Step the cursor left, wrapping at zero and capping at the top index
  always_comb begin
    logic [bdts_pkg::CursorW-1:0] c;
    c = (cur.cursor == bdts_pkg::CUR_FIRST) ? top : cur.cursor - 2'd1;
    cur_dec = (c > top) ? top : c;
  end

  // Apply one transaction to the edit state
  always_comb begin
    nxt    = cur;
    commit = 1'b0;
    if (item.opcode == bdts_pkg::OP_LOAD) begin
      nxt.year   = item.load_year;
      nxt.month  = item.load_month;
      nxt.day    = item.load_day;
      nxt.hour   = item.load_hour;
      nxt.minute = item.load_minute;
    end else begin
      case (item.key)
        bdts_pkg::KEY_SELECT: begin
          commit     = 1'b1;
          nxt.cursor = bdts_pkg::CUR_FIRST;
        end
        bdts_pkg::KEY_RIGHT: begin
          nxt.cursor = (cur_inc > {1'b0, top}) ? bdts_pkg::CUR_FIRST
                                               : cur_inc[bdts_pkg::CursorW-1:0];
        end
        bdts_pkg::KEY_LEFT: begin
          nxt.cursor = cur_dec;
        end
        bdts_pkg::KEY_UP, bdts_pkg::KEY_DOWN: begin
          if (item.edit_mode == bdts_pkg::MODE_DATE) begin
            // Day wraps at month length; left alone for an invalid month
            if (cur.cursor == bdts_pkg::CUR_FIRST) begin
              if (len != 5'd0) begin
                if (up) begin
                  nxt.day = (day_inc > {1'b0, len}) ? 5'd1
                                                    : day_inc[bdts_pkg::DayW-1:0];
                end else begin
                  nxt.day = (cur.day < 5'd2) ? len : cur.day - 5'd1;
                end
              end
            end else if (cur.cursor == bdts_pkg::CUR_SECOND) begin
              if (up) begin
                nxt.month = (month_inc > {1'b0, bdts_pkg::MONTH_LAST}) ? 4'd1
                            : month_inc[bdts_pkg::MonthW-1:0];
              end else begin
                nxt.month = (cur.month < 4'd2) ? bdts_pkg::MONTH_LAST
                                               : cur.month - 4'd1;
              end
            end else if (cur.cursor == bdts_pkg::CUR_THIRD) begin
              // Clamp the year, each bound tested on its own
              if (up) begin
                if (cur.year < year_max) nxt.year = cur.year + 12'd1;
              end else begin
                if (cur.year > year_min) nxt.year = cur.year - 12'd1;
              end
            end
          end else begin
            if (cur.cursor == bdts_pkg::CUR_FIRST) begin
              if (up) begin
                nxt.hour = (hour_inc > {1'b0, bdts_pkg::HOUR_LAST}) ? 5'd0
                           : hour_inc[bdts_pkg::HourW-1:0];
              end else begin
                nxt.hour = (cur.hour == 5'd0) ? bdts_pkg::HOUR_LAST
                                              : cur.hour - 5'd1;
              end
            end else if (cur.cursor == bdts_pkg::CUR_SECOND) begin
              if (up) begin
                nxt.minute = (minute_inc > {1'b0, bdts_pkg::MINUTE_LAST}) ? 6'd0
                             : minute_inc[bdts_pkg::MinuteW-1:0];
              end else begin
                nxt.minute = (cur.minute == 6'd0) ? bdts_pkg::MINUTE_LAST
                                                  : cur.minute - 6'd1;
              end
            end
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

// ----- src/button_date_time_setter.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Handshake         Payload
// in_      slave      tvalid / tready   tuser: opcode; tdata: key .. load_minute
// out_     master     tvalid / tready   tdata: day_out .. commit
// cfg_     write      cfg_wr_en         cfg_addr selects year_min / year_max
//
// One transaction per cycle sustained while out_tready is high; a result
// passes through the input register, then the result register.
// The edit state updates as an item passes from the input register into the
// result register, so the next item sees it with no bubble.
// A stalled output holds its result; the input register refills behind it.
// Reset (synchronous, rst_n low) restores the edit state and the year bounds.

module button_date_time_setter (
  input  logic                              clk,
  input  logic                              rst_n,
  // [0] opcode
  input  logic                              in_tuser,
  // [2:0] key, [3] edit_mode, [15:4] load_year, [19:16] load_month,
  // [24:20] load_day, [29:25] load_hour, [35:30] load_minute, [39:36] zero
  input  logic [bdts_pkg::InDataW-1:0]      in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [4:0] day_out, [8:5] month_out, [20:9] year_out, [25:21] hour_out,
  // [31:26] minute_out, [33:32] cursor_out, [34] commit, [39:35] zero
  output logic [bdts_pkg::OutDataW-1:0]     out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_addr,
  input  logic [bdts_pkg::YearW-1:0]        cfg_wdata
);

  bdts_pkg::item_t              in_item;
  bdts_pkg::item_t              item_r;
  logic                         in_vld_r;
  bdts_pkg::state_t             state_r;
  bdts_pkg::state_t             state_nxt;
  logic                         commit_nxt;
  logic [bdts_pkg::YearW-1:0]   year_min_r;
  logic [bdts_pkg::YearW-1:0]   year_max_r;
  logic [bdts_pkg::OutDataW-1:0] out_data_r;
  logic                         out_vld_r;
  logic                         proc_fire;

  // Unpack the input transaction
  assign in_item.opcode      = in_tuser;
  assign in_item.key         = in_tdata[2:0];
  assign in_item.edit_mode   = in_tdata[3];
  assign in_item.load_year   = in_tdata[15:4];
  assign in_item.load_month  = in_tdata[19:16];
  assign in_item.load_day    = in_tdata[24:20];
  assign in_item.load_hour   = in_tdata[29:25];
  assign in_item.load_minute = in_tdata[35:30];

  // Advance an item when the result register is free or draining
  assign proc_fire = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || proc_fire;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_min_r <= bdts_pkg::YEAR_MIN_RST;
      year_max_r <= bdts_pkg::YEAR_MAX_RST;
    end else if (cfg_wr_en) begin
      if (cfg_addr == bdts_pkg::CFG_YEAR_MIN) year_min_r <= cfg_wdata;
      if (cfg_addr == bdts_pkg::CFG_YEAR_MAX) year_max_r <= cfg_wdata;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= in_item;
    end
  end

  bdts_calc u_calc (
    .cur      (state_r),
    .item     (item_r),
    .year_min (year_min_r),
    .year_max (year_max_r),
    .nxt      (state_nxt),
    .commit   (commit_nxt)
  );

  // Update the edit state as the item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.day    <= bdts_pkg::DAY_RST;
      state_r.month  <= bdts_pkg::MONTH_RST;
      state_r.year   <= bdts_pkg::YEAR_RST;
      state_r.hour   <= bdts_pkg::HOUR_RST;
      state_r.minute <= bdts_pkg::MINUTE_RST;
      state_r.cursor <= bdts_pkg::CURSOR_RST;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_data_r <= {5'd0, commit_nxt, state_nxt.cursor, state_nxt.minute,
                     state_nxt.hour, state_nxt.year, state_nxt.month,
                     state_nxt.day};
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_vld_r;

  // The cursor never reaches an index beyond the date fields
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cursor != 2'd3)
    else $error("cursor out of range");

  // A commit result always shows the cursor back at the first field
  a_commit_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_data_r[34] |-> out_data_r[33:32] == bdts_pkg::CUR_FIRST)
    else $error("commit with cursor not reset");

  // A processed item always lands in the result register
  a_proc_out: assert property (@(posedge clk) disable iff (!rst_n)
    proc_fire |=> out_vld_r)
    else $error("processed item lost");

  // A waiting input item is not overwritten while blocked
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proc_fire |=> in_vld_r && $stable(item_r))
    else $error("blocked input item changed");

endmodule

// ----- tb/tb_button_date_time_setter.sv -----
`timescale 1ns / 1ps

import bdts_pkg::*;

// One result word as it sits on out_tdata, lowest field last
typedef struct packed {
  logic [4:0]         pad;
  logic               commit;
  logic [CursorW-1:0] cursor;
  logic [MinuteW-1:0] minute;
  logic [HourW-1:0]   hour;
  logic [YearW-1:0]   year;
  logic [MonthW-1:0]  month;
  logic [DayW-1:0]    day;
} edit_view_t;

class edit_scoreboard;
  logic [YearW-1:0]   lo_year;
  logic [YearW-1:0]   hi_year;
  logic [DayW-1:0]    day;
  logic [MonthW-1:0]  month;
  logic [YearW-1:0]   year;
  logic [HourW-1:0]   hour;
  logic [MinuteW-1:0] minute;
  logic [CursorW-1:0] cursor;
  edit_view_t         view_q[$];
  int                 fails;

  function new();
    fails = 0;
    reset_state();
  endfunction

  function void reset_state();
    lo_year = 12'd2017;
    hi_year = 12'd2117;
    day     = 5'd1;
    month   = 4'd1;
    year    = 12'd2017;
    hour    = 5'd12;
    minute  = 6'd0;
    cursor  = CUR_FIRST;
    view_q.delete();
  endfunction

  function void set_bound(logic addr, logic [YearW-1:0] value);
    if (addr == CFG_YEAR_MIN) lo_year = value;
    else hi_year = value;
  endfunction

  function int pending();
    return view_q.size();
  endfunction

  // Gregorian month length, zero for a month outside 1..12
  function int unsigned days_in(int unsigned m, int unsigned y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Step the edit state for one accepted transaction and queue the view
  function void note_item(logic op, logic [InDataW-1:0] d);
    logic [KeyW-1:0] key;
    logic            mode;
    logic            commit;
    logic            up;
    int unsigned     top;
    int unsigned     len;
    edit_view_t      v;
    key    = d[2:0];
    mode   = d[3];
    commit = 1'b0;
    up     = (key == KEY_UP);
    top    = (mode == MODE_DATE) ? CUR_TOP_DATE : CUR_TOP_TIME;
    if (op == OP_LOAD) begin
      year   = d[15:4];
      month  = d[19:16];
      day    = d[24:20];
      hour   = d[29:25];
      minute = d[35:30];
    end else begin
      case (key)
        KEY_SELECT: begin
          commit = 1'b1;
          cursor = CUR_FIRST;
        end
        KEY_RIGHT: begin
          cursor = (cursor + 1 > top) ? CUR_FIRST : CursorW'(cursor + 1);
        end
        KEY_LEFT: begin
          // wrap to the top index, and pull an out-of-range cursor back
          if (cursor == CUR_FIRST) cursor = CursorW'(top);
          else cursor = cursor - 1'b1;
          if (cursor > top) cursor = CursorW'(top);
        end
        KEY_UP, KEY_DOWN: begin
          if (mode == MODE_DATE) begin
            if (cursor == CUR_FIRST) begin
              len = days_in(month, year);
              if (len != 0) begin
                if (up) day = (day + 1 > len) ? 5'd1 : DayW'(day + 1);
                else day = (day < 2) ? DayW'(len) : DayW'(day - 1);
              end
            end else if (cursor == CUR_SECOND) begin
              if (up) month = (month + 1 > 12) ? 4'd1 : MonthW'(month + 1);
              else month = (month < 2) ? 4'd12 : MonthW'(month - 1);
            end else if (cursor == CUR_THIRD) begin
              if (up) begin
                if (year < hi_year) year = year + 1'b1;
              end else begin
                if (year > lo_year) year = year - 1'b1;
              end
            end
          end else begin
            if (cursor == CUR_FIRST) begin
              if (up) hour = (hour + 1 > 23) ? 5'd0 : HourW'(hour + 1);
              else hour = (hour == 0) ? 5'd23 : hour - 1'b1;
            end else if (cursor == CUR_SECOND) begin
              if (up) minute = (minute + 1 > 59) ? 6'd0 : MinuteW'(minute + 1);
              else minute = (minute == 0) ? 6'd59 : minute - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    v.pad    = '0;
    v.commit = commit;
    v.cursor = cursor;
    v.minute = minute;
    v.hour   = hour;
    v.year   = year;
    v.month  = month;
    v.day    = day;
    view_q.push_back(v);
  endfunction

  function void match_field(string label, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      fails++;
    end
  endfunction

  function void check_result(logic [OutDataW-1:0] d);
    edit_view_t got;
    edit_view_t want;
    got = d;
    if (view_q.size() == 0) begin
      $display("%0t: unexpected result: expected none, actual %h", $time, d);
      fails++;
    end else begin
      want = view_q.pop_front();
      match_field("day_out", want.day, got.day);
      match_field("month_out", want.month, got.month);
      match_field("year_out", want.year, got.year);
      match_field("hour_out", want.hour, got.hour);
      match_field("minute_out", want.minute, got.minute);
      match_field("cursor_out", want.cursor, got.cursor);
      match_field("commit", want.commit, got.commit);
    end
  endfunction
endclass

module tb_button_date_time_setter;

  localparam int LIMIT       = 200000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int TX_QUIET_LO = 600;
  localparam int TX_QUIET_HI = 900;
  localparam int RX_QUIET_LO = 650;
  localparam int RX_QUIET_HI = 950;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_tuser  = 1'b0;
  logic [InDataW-1:0]   in_tdata  = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [OutDataW-1:0]  out_tdata;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic                 cfg_wr_en  = 1'b0;
  logic                 cfg_addr   = 1'b0;
  logic [YearW-1:0]     cfg_wdata  = '0;

  edit_scoreboard sb = new();
  int  cycle_count = 0;
  int  tx_count    = 0;
  int  rx_count    = 0;
  int  hold_left   = 0;
  logic cur_mode   = MODE_DATE;

  button_date_time_setter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [InDataW-1:0] pack_item(
      logic [KeyW-1:0] key, logic mode, logic [YearW-1:0] y, logic [MonthW-1:0] m,
      logic [DayW-1:0] d, logic [HourW-1:0] h, logic [MinuteW-1:0] mi);
    return {4'b0, mi, h, d, m, y, mode, key};
  endfunction

  // After random idle gaps, offer one item, hold it until accepted, then log it
  task automatic send_item(logic op, logic [InDataW-1:0] d);
    while (!(tx_count >= TX_QUIET_LO && tx_count < TX_QUIET_HI) &&
           $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, d);
    tx_count++;
  endtask

  task automatic press(logic [KeyW-1:0] key, logic mode);
    send_item(OP_BUTTON, pack_item(key, mode, '0, '0, '0, '0, '0));
  endtask

  task automatic load(logic [YearW-1:0] y, logic [MonthW-1:0] m, logic [DayW-1:0] d,
                      logic [HourW-1:0] h, logic [MinuteW-1:0] mi);
    send_item(OP_LOAD, pack_item(KeyW'($urandom), 1'($urandom_range(1)), y, m, d, h, mi));
  endtask

  // Drop valid and wait until every result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bound(logic addr, logic [YearW-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_bound(addr, value);
    @(posedge clk);
  endtask

  // Mostly edits in a sticky mode, with loads of random years, years near the year bounds and multiples of 100
  task automatic run_random(int n);
    int              r;
    logic [KeyW-1:0] key;
    logic [YearW-1:0] y;
    repeat (n) begin
      if ($urandom_range(99) < 8) cur_mode = ~cur_mode;
      r = $urandom_range(99);
      if (r < 10) begin
        case ($urandom_range(3))
          0:       y = YearW'($urandom);
          1:       y = sb.lo_year + YearW'($urandom_range(4)) - 12'd2;
          2:       y = sb.hi_year + YearW'($urandom_range(4)) - 12'd2;
          default: y = YearW'(100 * $urandom_range(40));
        endcase
        if ($urandom_range(99) < 70)
          load(y, MonthW'($urandom_range(12, 1)), DayW'($urandom_range(31, 1)),
               HourW'($urandom_range(23)), MinuteW'($urandom_range(59)));
        else
          load(y, MonthW'($urandom), DayW'($urandom), HourW'($urandom),
               MinuteW'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 30)      key = KEY_UP;
        else if (r < 60) key = KEY_DOWN;
        else if (r < 72) key = KEY_RIGHT;
        else if (r < 84) key = KEY_LEFT;
        else if (r < 92) key = KEY_SELECT;
        else             key = KeyW'($urandom_range({KeyW{1'b1}}, KEY_NONE));
        send_item(OP_BUTTON, pack_item(key, cur_mode, YearW'($urandom), MonthW'($urandom),
                                       DayW'($urandom), HourW'($urandom),
                                       MinuteW'($urandom)));
      end
    end
  endtask

  // Receive results, with random stalls, one long hold and a quiet stretch
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        sb.check_result(out_tdata);
        rx_count++;
        if (rx_count == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_count >= RX_QUIET_LO && rx_count < RX_QUIET_HI) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 13);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each key, most in both modes, wraps, clamps and odd loads
    press(KEY_SELECT, MODE_DATE);
    press(KEY_DOWN, MODE_DATE);
    press(KEY_UP, MODE_DATE);
    press(KEY_RIGHT, MODE_DATE);
    press(KEY_DOWN, MODE_DATE);
    press(KEY_UP, MODE_DATE);
    press(KEY_RIGHT, MODE_DATE);
    press(KEY_DOWN, MODE_DATE);
    press(KEY_UP, MODE_DATE);
    press(KEY_RIGHT, MODE_DATE);
    press(KEY_LEFT, MODE_DATE);
    press(KEY_LEFT, MODE_DATE);
    press(KEY_UP, MODE_TIME);
    press(KEY_DOWN, MODE_TIME);
    press(KEY_DOWN, MODE_TIME);
    press(KEY_LEFT, MODE_TIME);
    press(KEY_DOWN, MODE_TIME);
    load(12'd2000, 4'd2, 5'd29, 5'd23, 6'd59);
    press(KEY_UP, MODE_TIME);
    press(KEY_UP, MODE_DATE);
    load(12'd1900, 4'd2, 5'd28, 5'd0, 6'd0);
    press(KEY_UP, MODE_DATE);
    load(12'd4095, 4'd15, 5'd31, 5'd31, 6'd63);
    press(KEY_UP, MODE_DATE);
    press(KEY_UP, MODE_TIME);
    press(KEY_NONE, MODE_DATE);
    press(KEY_RIGHT, MODE_DATE);
    press(KEY_RIGHT, MODE_DATE);
    press(KEY_UP, MODE_TIME);
    press(KEY_RIGHT, MODE_TIME);
    load(12'd0, 4'd0, 5'd0, 5'd0, 6'd0);
    press(KEY_UP, MODE_DATE);
    drain();

    run_random(375);
    drain();

    write_bound(CFG_YEAR_MIN, 12'd0);
    write_bound(CFG_YEAR_MAX, 12'd4095);
    run_random(300);
    drain();

    // Crossed bounds
    write_bound(CFG_YEAR_MIN, 12'd3000);
    write_bound(CFG_YEAR_MAX, 12'd1000);
    run_random(300);
    drain();

    write_bound(CFG_YEAR_MIN, 12'd2024);
    write_bound(CFG_YEAR_MAX, 12'd2024);
    run_random(250);
    drain();

    write_bound(CFG_YEAR_MIN, 12'd1996);
    write_bound(CFG_YEAR_MAX, 12'd2004);
    run_random(300);
    drain();

    repeat (10) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
